// File: hdl/sac_pkg.sv
// ----------------------------------------------------------------------------
// sac_pkg: shared definitions for the switching activity counter
// Default widths, operation and level codes, and configuration register
// indexes used by the channel interfaces and the core.
// ----------------------------------------------------------------------------
package sac_pkg;

	// Default widths of the time base, the transition counter and the fraction.
	localparam int TIME_WIDTH_DEFAULT    = 48;
	localparam int COUNT_WIDTH_DEFAULT   = 32;
	localparam int FRACTION_BITS_DEFAULT = 16;

	// Fixed widths of the configuration registers and the activity result.
	localparam int END_WIDTH      = 48;
	localparam int PERIOD_WIDTH   = 32;
	localparam int ACTIVITY_WIDTH = 40;

	// APB data and address widths.
	localparam int APB_DATA_WIDTH = 64;
	localparam int APB_ADDR_WIDTH = 4;

	// Operation codes carried with every request.
	localparam logic OP_SAMPLE = 1'b0;
	localparam logic OP_FINISH = 1'b1;

	// Four-state level codes.
	localparam logic [1:0] LEVEL_ZERO = 2'd0;
	localparam logic [1:0] LEVEL_ONE  = 2'd1;
	localparam logic [1:0] LEVEL_X    = 2'd2;
	localparam logic [1:0] LEVEL_Z    = 2'd3;

	// Register select, taken from address bit 3 (registers sit 8 bytes apart).
	localparam logic REG_WINDOW = 1'b0;
	localparam logic REG_PERIOD = 1'b1;

endpackage

// File: hdl/sac_if.sv
// ----------------------------------------------------------------------------
// sac_if: request and result channels of the switching activity counter
// Valid/ready channels; a request moves when valid and ready are both high.
// ----------------------------------------------------------------------------

// Sample and finish requests.
interface sac_in_if #(
	parameter int TIME_WIDTH = sac_pkg::TIME_WIDTH_DEFAULT
);
	logic                  valid;
	logic                  ready;
	logic                  op;
	logic [TIME_WIDTH-1:0] sample_time;
	logic [1:0]            level;

	modport source (output valid, output op, output sample_time, output level, input ready);
	modport sink   (input valid, input op, input sample_time, input level, output ready);
endinterface

// Result items, one for each finish request.
interface sac_out_if #(
	parameter int COUNT_WIDTH   = sac_pkg::COUNT_WIDTH_DEFAULT,
	parameter int FRACTION_BITS = sac_pkg::FRACTION_BITS_DEFAULT
);
	logic                              valid;
	logic                              ready;
	logic [FRACTION_BITS:0]            duty_q16;
	logic [sac_pkg::ACTIVITY_WIDTH-1:0] activity_q16;
	logic [COUNT_WIDTH-1:0]            transition_halves;
	logic                              no_samples;
	logic                              saturated;

	modport source (output valid, output duty_q16, output activity_q16,
		output transition_halves, output no_samples, output saturated, input ready);
	modport sink   (input valid, input duty_q16, input activity_q16,
		input transition_halves, input no_samples, input saturated, output ready);
endinterface

// File: hdl/switching_activity_counter_core.sv
// ----------------------------------------------------------------------------
// switching_activity_counter_core: toggle rate and duty cycle of one signal
// Accumulates high time and half-unit transitions from value changes and,
// on finish, divides them into a Q1.16 duty cycle and a Q24.16 activity.
// ----------------------------------------------------------------------------
// Usage:
// Requests arrive on the samples channel. A sample request (op = 0) carries a
// time and a four-state level and is absorbed in the cycle it is accepted; it
// gives no result. A finish request (op = 1) closes the record at the end of
// the window, clears the accumulators at once and starts the finish sequence.
// The finish sequence runs one shared restoring divider, one quotient bit per
// cycle, over the numerator width N = max(TIME_WIDTH + FRACTION_BITS,
// COUNT_WIDTH + 31 + FRACTION_BITS) twice, with a 32-step shift-add multiply
// in between. A result is loaded into the output register when the sequence
// ends, or straight from ST_DONE after a finish with no samples, which skips
// the divider; samples.ready stays low meanwhile.
// Samples go at one per cycle while no finish sequence is running.
// One result sits in the output register; while it waits for results.ready,
// sample requests are still accepted, and a later finish waits for the slot.
// The window length (address 0) and clock_period_ticks (address 8) are
// written over APB and reset to 1. Reset clears all accumulators and empties
// the output.
// ----------------------------------------------------------------------------
module switching_activity_counter_core #(
	parameter int TIME_WIDTH    = sac_pkg::TIME_WIDTH_DEFAULT,
	parameter int COUNT_WIDTH   = sac_pkg::COUNT_WIDTH_DEFAULT,
	parameter int FRACTION_BITS = sac_pkg::FRACTION_BITS_DEFAULT
) (
	input  logic                               clk,
	input  logic                               arst_n,
	sac_in_if.sink                             samples,
	sac_out_if.source                          results,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic [sac_pkg::APB_ADDR_WIDTH-1:0] paddr,
	input  logic [sac_pkg::APB_DATA_WIDTH-1:0] pwdata,
	output logic [sac_pkg::APB_DATA_WIDTH-1:0] prdata,
	output logic                               pready
);

	localparam int TW      = TIME_WIDTH;
	localparam int CW      = COUNT_WIDTH;
	localparam int FB      = FRACTION_BITS;
	localparam int PW      = sac_pkg::PERIOD_WIDTH;
	localparam int AW      = sac_pkg::ACTIVITY_WIDTH;
	localparam int PROD_W  = CW + PW;
	localparam int DUTY_NW = TW + FB;
	localparam int ACT_NW  = PROD_W + FB - 1;
	localparam int NUM_W   = (DUTY_NW > ACT_NW) ? DUTY_NW : ACT_NW;
	localparam int CNT_W   = $clog2(NUM_W + 1);

	typedef enum logic [2:0] {
		ST_IDLE,
		ST_DUTY,
		ST_MUL,
		ST_ACT,
		ST_DONE
	} state_t;

	state_t state_q;

	// Configuration registers.
	logic [sac_pkg::END_WIDTH-1:0] window_len_q;
	logic [PW-1:0]                 period_q;

	// Accumulated record of the signal.
	logic [1:0]    prev_level_q;
	logic [TW-1:0] prev_time_q;
	logic [TW-1:0] high_q;
	logic [CW-1:0] half_q;
	logic          have_q;
	logic          ovf_q;

	// Working registers of the finish sequence.
	logic [NUM_W-1:0] num_q;
	logic [TW-1:0]    rem_q;
	logic [TW-1:0]    div_q;
	logic [AW-1:0]    quo_q;
	logic             big_q;
	logic [CNT_W-1:0] cnt_q;
	logic [CW-1:0]    mcand_q;
	logic [PW-1:0]    mplier_q;
	logic [PROD_W-1:0] prod_q;
	logic [FB:0]      duty_res_q;
	logic             sat_q;
	logic             no_samp_q;

	// Output register.
	logic             out_valid_q;
	logic [FB:0]      duty_out_q;
	logic [AW-1:0]    act_out_q;
	logic [CW-1:0]    halves_out_q;
	logic             no_samp_out_q;
	logic             sat_out_q;

	logic in_fire;
	logic out_free;
	logic is_finish;
	logic cfg_write;

	assign in_fire   = samples.valid && samples.ready;
	assign out_free  = !out_valid_q || results.ready;
	assign is_finish = (samples.op == sac_pkg::OP_FINISH);
	assign cfg_write = psel && penable && pwrite && pready;

	assign samples.ready = (state_q == ST_IDLE);

	assign results.valid             = out_valid_q;
	assign results.duty_q16          = duty_out_q;
	assign results.activity_q16      = act_out_q;
	assign results.transition_halves = halves_out_q;
	assign results.no_samples        = no_samp_out_q;
	assign results.saturated         = sat_out_q;

	// APB register file.
	assign pready = 1'b1;

	always_comb begin
		if (paddr[3] == sac_pkg::REG_PERIOD) begin
			prdata = sac_pkg::APB_DATA_WIDTH'(period_q);
		end else begin
			prdata = sac_pkg::APB_DATA_WIDTH'(window_len_q);
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			window_len_q <= sac_pkg::END_WIDTH'(1);
			period_q     <= PW'(1);
		end else if (cfg_write) begin
			if (paddr[3] == sac_pkg::REG_PERIOD) begin
				period_q <= pwdata[PW-1:0];
			end else begin
				window_len_q <= pwdata[sac_pkg::END_WIDTH-1:0];
			end
		end
	end

	// Divisor: end time masked to the time width, zero taken as one.
	logic [TW-1:0] end_ext;
	logic [TW-1:0] end_eff;

	assign end_ext = TW'(window_len_q);
	assign end_eff = (end_ext == '0) ? TW'(1) : end_ext;

	// High-time accumulation up to the sample time, or to the end on finish.
	logic [TW-1:0] now;
	logic [TW:0]   diff;
	logic [TW:0]   high_sum;
	logic          high_add;
	logic [TW-1:0] high_next;
	logic          high_ovf;

	always_comb begin
		now       = is_finish ? end_eff : samples.sample_time;
		diff      = {1'b0, now} - {1'b0, prev_time_q};
		high_add  = (prev_level_q == sac_pkg::LEVEL_ONE) && !diff[TW];
		high_sum  = {1'b0, high_q} + {1'b0, diff[TW-1:0]};
		high_ovf  = high_add && high_sum[TW];
		if (!high_add) begin
			high_next = high_q;
		end else if (high_sum[TW]) begin
			high_next = '1;
		end else begin
			high_next = high_sum[TW-1:0];
		end
	end

	// Transition count: a change between known levels counts two halves.
	logic          level_changed;
	logic [1:0]    half_inc;
	logic [CW:0]   half_sum;
	logic [CW-1:0] half_next;
	logic          half_ovf;

	always_comb begin
		level_changed = (samples.level != prev_level_q);
		if ((samples.level inside {sac_pkg::LEVEL_X, sac_pkg::LEVEL_Z}) ||
			(prev_level_q inside {sac_pkg::LEVEL_X, sac_pkg::LEVEL_Z})) begin
			half_inc = 2'd1;
		end else begin
			half_inc = 2'd2;
		end
		half_sum = {1'b0, half_q} + (CW + 1)'(half_inc);
		half_ovf = level_changed && half_sum[CW];
		if (!level_changed) begin
			half_next = half_q;
		end else if (half_sum[CW]) begin
			half_next = '1;
		end else begin
			half_next = half_sum[CW-1:0];
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			prev_level_q <= sac_pkg::LEVEL_ZERO;
			prev_time_q  <= '0;
			high_q       <= '0;
			half_q       <= '0;
			have_q       <= 1'b0;
			ovf_q        <= 1'b0;
		end else if (in_fire) begin
			if (is_finish) begin
				prev_level_q <= sac_pkg::LEVEL_ZERO;
				prev_time_q  <= '0;
				high_q       <= '0;
				half_q       <= '0;
				have_q       <= 1'b0;
				ovf_q        <= 1'b0;
			end else begin
				if (have_q) begin
					high_q <= high_next;
					half_q <= half_next;
					ovf_q  <= ovf_q || high_ovf || half_ovf;
				end
				prev_level_q <= samples.level;
				prev_time_q  <= samples.sample_time;
				have_q       <= 1'b1;
			end
		end
	end

	// Shared restoring divider step: one quotient bit per cycle.
	logic [TW:0]      div_cand;
	logic             div_ge;
	logic [TW:0]      div_diff;
	logic [TW-1:0]    rem_step;
	logic [AW-1:0]    quo_step;
	logic             big_step;

	always_comb begin
		div_cand = {rem_q, num_q[NUM_W-1]};
		div_ge   = (div_cand >= {1'b0, div_q});
		div_diff = div_cand - {1'b0, div_q};
		rem_step = div_ge ? div_diff[TW-1:0] : div_cand[TW-1:0];
		quo_step = {quo_q[AW-2:0], div_ge};
		big_step = big_q || quo_q[AW-1];
	end

	// Shift-add multiply step, multiplier bits taken from the top.
	logic [PROD_W-1:0] prod_step;

	assign prod_step = {prod_q[PROD_W-2:0], 1'b0} +
		(mplier_q[PW-1] ? PROD_W'(mcand_q) : '0);

	// Duty limit and its saturation test.
	localparam logic [AW-1:0] DUTY_LIMIT = AW'(1) << FB;
	logic duty_sat;

	assign duty_sat = big_q || (quo_q > DUTY_LIMIT);

	// Working registers of the finish sequence.
	always_ff @(posedge clk) begin
		case (state_q)
			ST_IDLE: begin
				if (in_fire && is_finish) begin
					num_q     <= NUM_W'({high_next, {FB{1'b0}}});
					rem_q     <= '0;
					quo_q     <= '0;
					big_q     <= 1'b0;
					cnt_q     <= CNT_W'(NUM_W);
					div_q     <= end_eff;
					mcand_q   <= half_q;
					sat_q     <= ovf_q || high_ovf;
					no_samp_q <= !have_q;
				end
			end
			ST_DUTY: begin
				if (cnt_q != '0) begin
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					rem_q <= rem_step;
					quo_q <= quo_step;
					big_q <= big_step;
					cnt_q <= cnt_q - CNT_W'(1);
				end else begin
					duty_res_q <= duty_sat ? DUTY_LIMIT[FB:0] : quo_q[FB:0];
					sat_q      <= sat_q || duty_sat;
					prod_q     <= '0;
					mplier_q   <= period_q;
					cnt_q      <= CNT_W'(PW);
				end
			end
			ST_MUL: begin
				if (cnt_q != '0) begin
					prod_q   <= prod_step;
					mplier_q <= {mplier_q[PW-2:0], 1'b0};
					cnt_q    <= cnt_q - CNT_W'(1);
				end else begin
					num_q <= NUM_W'({prod_q, {(FB - 1){1'b0}}});
					rem_q <= '0;
					quo_q <= '0;
					big_q <= 1'b0;
					cnt_q <= CNT_W'(NUM_W);
				end
			end
			ST_ACT: begin
				if (cnt_q != '0) begin
					num_q <= {num_q[NUM_W-2:0], 1'b0};
					rem_q <= rem_step;
					quo_q <= quo_step;
					big_q <= big_step;
					cnt_q <= cnt_q - CNT_W'(1);
				end
			end
			default: begin
			end
		endcase
	end

	// Sequencer and output register.
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q       <= ST_IDLE;
			out_valid_q   <= 1'b0;
			duty_out_q    <= '0;
			act_out_q     <= '0;
			halves_out_q  <= '0;
			no_samp_out_q <= 1'b0;
			sat_out_q     <= 1'b0;
		end else begin
			if (state_q == ST_DONE && out_free) begin
				out_valid_q <= 1'b1;
			end else if (results.ready) begin
				out_valid_q <= 1'b0;
			end
			case (state_q)
				ST_IDLE: begin
					if (in_fire && is_finish) begin
						state_q <= have_q ? ST_DUTY : ST_DONE;
					end
				end
				ST_DUTY: begin
					if (cnt_q == '0) begin
						state_q <= ST_MUL;
					end
				end
				ST_MUL: begin
					if (cnt_q == '0) begin
						state_q <= ST_ACT;
					end
				end
				ST_ACT: begin
					if (cnt_q == '0) begin
						state_q <= ST_DONE;
					end
				end
				ST_DONE: begin
					// The result waits here until the output register is free.
					if (out_free) begin
						if (no_samp_q) begin
							duty_out_q    <= '0;
							act_out_q     <= '0;
							halves_out_q  <= '0;
							sat_out_q     <= 1'b0;
							no_samp_out_q <= 1'b1;
						end else begin
							// Activity can only overflow the quotient width.
							act_out_q     <= big_q ? '1 : quo_q;
							sat_out_q     <= sat_q || big_q;
							duty_out_q    <= duty_res_q;
							halves_out_q  <= mcand_q;
							no_samp_out_q <= 1'b0;
						end
						state_q <= ST_IDLE;
					end
				end
				default: begin
					state_q <= ST_IDLE;
				end
			endcase
		end
	end

	// A result with no samples carries nothing else.
	assert property (@(posedge clk) disable iff (!arst_n)
		(results.valid && results.no_samples) |->
		(results.duty_q16 == '0 && results.activity_q16 == '0 &&
		results.transition_halves == '0 && !results.saturated))
		else $error("no-sample result carries nonzero fields");

	// Duty never exceeds one.
	assert property (@(posedge clk) disable iff (!arst_n)
		results.valid |-> (AW'(results.duty_q16) <= DUTY_LIMIT))
		else $error("duty above full scale");

	// Accumulators never fall while samples arrive.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && !is_finish) |=> (half_q >= $past(half_q) && high_q >= $past(high_q)))
		else $error("accumulator decreased on a sample");

	// A finish clears the record in the next cycle.
	assert property (@(posedge clk) disable iff (!arst_n)
		(in_fire && is_finish) |=> (!have_q && half_q == '0 && high_q == '0 && !ovf_q))
		else $error("record not cleared after finish");

	// A pending result is never overwritten before it is taken.
	assert property (@(posedge clk) disable iff (!arst_n)
		(out_valid_q && !results.ready) |=>
		(out_valid_q && $stable(duty_out_q) && $stable(act_out_q) && $stable(sat_out_q)))
		else $error("pending result lost");

endmodule

// File: dv/switching_activity_counter_checker.sv
// ----------------------------------------------------------------------------
// switching_activity_counter_checker: result checker for the activity counter
// Watches the register port and both channels, keeps its own record of the
// signal under measurement, works out the result of every finish request and
// compares it field by field with what the core returns.
// ----------------------------------------------------------------------------
module switching_activity_counter_checker (
	input  logic                               clk,
	input  logic                               arst_n,
	sac_in_if                                  samples,
	sac_out_if                                 results,
	input  logic                               psel,
	input  logic                               penable,
	input  logic                               pwrite,
	input  logic                               pready,
	input  logic [sac_pkg::APB_ADDR_WIDTH-1:0] paddr,
	input  logic [sac_pkg::APB_DATA_WIDTH-1:0] pwdata,
	output int                                 failures,
	output int                                 pending,
	output int                                 checked
);
	timeunit 1ns;
	timeprecision 1ps;

	localparam int TW = sac_pkg::TIME_WIDTH_DEFAULT;
	localparam int CW = sac_pkg::COUNT_WIDTH_DEFAULT;
	localparam int FB = sac_pkg::FRACTION_BITS_DEFAULT;

	localparam logic [TW-1:0] TIME_FULL  = '1;
	localparam logic [CW-1:0] COUNT_FULL = '1;
	localparam logic [63:0]   DUTY_FULL  = 64'd1 << FB;
	localparam logic [63:0]   ACT_FULL   = (64'd1 << sac_pkg::ACTIVITY_WIDTH) - 64'd1;

	// A change between zero and one is a whole transition, anything touching
	// X or Z is half of one.
	localparam logic [CW-1:0] HALF_STEP = 1;
	localparam logic [CW-1:0] FULL_STEP = 2;

	typedef struct packed {
		logic [FB:0]                        duty;
		logic [sac_pkg::ACTIVITY_WIDTH-1:0] activity;
		logic [CW-1:0]                      halves;
		logic                               no_samples;
		logic                               saturated;
	} activity_result_t;

	// Register copies and the running record of the measured signal.
	logic [sac_pkg::END_WIDTH-1:0]    window_cfg = 1;
	logic [sac_pkg::PERIOD_WIDTH-1:0] period_cfg = 1;
	logic [1:0]              last_level   = sac_pkg::LEVEL_ZERO;
	logic [TW-1:0]           last_time    = '0;
	logic [TW-1:0]           high_acc     = '0;
	logic [CW-1:0]           halves_acc   = '0;
	logic                    started      = 1'b0;
	logic                    overflowed   = 1'b0;

	activity_result_t expected_results[$];
	int errors   = 0;
	int compared = 0;

	function automatic void clear_record();
		last_level = sac_pkg::LEVEL_ZERO;
		last_time  = '0;
		high_acc   = '0;
		halves_acc = '0;
		started    = 1'b0;
		overflowed = 1'b0;
	endfunction

	// Add the stretch since the last change if the signal sat at one.
	// A time behind the last change adds nothing.
	function automatic void credit_high(input logic [TW-1:0] now);
		logic [TW-1:0] stretch;
		if (last_level == sac_pkg::LEVEL_ONE && now >= last_time) begin
			stretch = now - last_time;
			if (stretch > TIME_FULL - high_acc) begin
				high_acc   = TIME_FULL;
				overflowed = 1'b1;
			end else begin
				high_acc = high_acc + stretch;
			end
		end
	endfunction

	function automatic void take_sample(input logic [TW-1:0] stamp, input logic [1:0] lv);
		logic [CW-1:0] step;
		if (started) begin
			credit_high(stamp);
			if (lv != last_level) begin
				if (lv == sac_pkg::LEVEL_X || lv == sac_pkg::LEVEL_Z ||
						last_level == sac_pkg::LEVEL_X ||
						last_level == sac_pkg::LEVEL_Z)
					step = HALF_STEP;
				else
					step = FULL_STEP;
				if (step > COUNT_FULL - halves_acc) begin
					halves_acc = COUNT_FULL;
					overflowed = 1'b1;
				end else begin
					halves_acc = halves_acc + step;
				end
			end
		end
		last_level = lv;
		last_time  = stamp;
		started    = 1'b1;
	endfunction

	// Truncating quotient, clamped to a ceiling.
	function automatic logic [63:0] clamp_quotient(input logic [127:0] num,
			input logic [TW-1:0] den, input logic [63:0] ceiling, output logic over);
		logic [127:0] quot;
		quot = num / {{(128-TW){1'b0}}, den};
		over = (quot > {64'd0, ceiling});
		return over ? ceiling : quot[63:0];
	endfunction

	// Close the record at the end of the window and derive duty and activity.
	function automatic activity_result_t close_record();
		activity_result_t res;
		logic [TW-1:0]    window;
		logic [127:0]     num;
		logic [63:0]      quot;
		logic             over;
		res = '0;
		if (!started) begin
			res.no_samples = 1'b1;
		end else begin
			window = window_cfg[TW-1:0];
			if (window == '0)
				window = 1;
			credit_high(window);
			res.saturated = overflowed;
			num = {{(128-TW){1'b0}}, high_acc} << FB;
			quot = clamp_quotient(num, window, DUTY_FULL, over);
			res.duty = quot[FB:0];
			res.saturated = res.saturated | over;
			if (period_cfg != '0 && halves_acc != '0) begin
				num = {{(128-CW){1'b0}}, halves_acc} *
					{{(128-sac_pkg::PERIOD_WIDTH){1'b0}}, period_cfg};
				num = num << (FB - 1);
				quot = clamp_quotient(num, window, ACT_FULL, over);
				res.activity = quot[sac_pkg::ACTIVITY_WIDTH-1:0];
				res.saturated = res.saturated | over;
			end
			res.halves = halves_acc;
		end
		clear_record();
		return res;
	endfunction

	task automatic compare_field(input string field, input logic [63:0] want,
			input logic [63:0] got);
		if (want !== got) begin
			$display("%0t ns: %s mismatch, expected %0d, got %0d", $time, field, want, got);
			errors++;
		end
	endtask

	// Everything is sampled at the rising edge, before the core's outputs move.
	always @(posedge clk) begin
		activity_result_t want;
		if (!arst_n) begin
			window_cfg = 1;
			period_cfg = 1;
			clear_record();
			expected_results.delete();
		end else begin
			// Register writes.
			if (psel && penable && pwrite && pready) begin
				if (paddr[3] == sac_pkg::REG_WINDOW)
					window_cfg = pwdata[sac_pkg::END_WIDTH-1:0];
				else
					period_cfg = pwdata[sac_pkg::PERIOD_WIDTH-1:0];
			end

			// Returned results against the oldest expectation.
			if (results.valid && results.ready) begin
				if (expected_results.size() == 0) begin
					$display("%0t ns: result with nothing expected:", $time);
					$display("  duty %0d activity %0d halves %0d",
						results.duty_q16, results.activity_q16,
						results.transition_halves);
					$display("  no_samples %0b saturated %0b",
						results.no_samples, results.saturated);
					errors++;
				end else begin
					want = expected_results.pop_front();
					compare_field("duty_q16", 64'(want.duty), 64'(results.duty_q16));
					compare_field("activity_q16", 64'(want.activity),
						64'(results.activity_q16));
					compare_field("transition_halves", 64'(want.halves),
						64'(results.transition_halves));
					compare_field("no_samples", 64'(want.no_samples), 64'(results.no_samples));
					compare_field("saturated", 64'(want.saturated), 64'(results.saturated));
					compared++;
				end
			end

			// Accepted requests update the record; a finish yields one result.
			if (samples.valid && samples.ready) begin
				if (samples.op == sac_pkg::OP_SAMPLE)
					take_sample(samples.sample_time, samples.level);
				else
					expected_results.push_back(close_record());
			end
		end
		failures <= errors;
		pending  <= expected_results.size();
		checked  <= compared;
	end
endmodule

// File: dv/switching_activity_counter_core_test.sv
// ----------------------------------------------------------------------------
// switching_activity_counter_core_test: testbench top for the activity counter
// Drives value-change traces and finish requests through the core under a
// series of register settings, with bursty requests and a stalling receiver,
// and leaves the comparison of results to the checker beside the core.
// ----------------------------------------------------------------------------
module switching_activity_counter_core_test;
	timeunit 1ns;
	timeprecision 1ps;

	localparam logic [sac_pkg::APB_ADDR_WIDTH-1:0] WINDOW_ADDR =
		{sac_pkg::REG_WINDOW, 3'b000};
	localparam logic [sac_pkg::APB_ADDR_WIDTH-1:0] PERIOD_ADDR =
		{sac_pkg::REG_PERIOD, 3'b000};
	localparam logic [47:0] TIME_TOP     = '1;
	localparam logic [31:0] PERIOD_TOP   = '1;
	localparam int          PHASE_ITEMS  = 117;
	localparam int          RANDOM_PHASES = 6;
	localparam int          LONG_HOLD_CYCLES = 1500;

	typedef enum {READY_OPEN, READY_COIN, READY_SPARSE} ready_mode_t;

	logic clk = 1'b0;
	logic arst_n;
	logic psel;
	logic penable;
	logic pwrite;
	logic [sac_pkg::APB_ADDR_WIDTH-1:0] paddr;
	logic [sac_pkg::APB_DATA_WIDTH-1:0] pwdata;
	logic [sac_pkg::APB_DATA_WIDTH-1:0] prdata;
	logic pready;

	int failures;
	int pending;
	int checked;
	int sent_items = 0;
	int sent_finishes = 0;
	int settings_used = 0;
	int burst_left = 0;
	bit stress_go = 1'b0;

	sac_in_if  samples ();
	sac_out_if results ();

	switching_activity_counter_core dut (
		.clk     (clk),
		.arst_n  (arst_n),
		.samples (samples),
		.results (results),
		.psel    (psel),
		.penable (penable),
		.pwrite  (pwrite),
		.paddr   (paddr),
		.pwdata  (pwdata),
		.prdata  (prdata),
		.pready  (pready)
	);

	switching_activity_counter_checker checker_i (
		.clk      (clk),
		.arst_n   (arst_n),
		.samples  (samples),
		.results  (results),
		.psel     (psel),
		.penable  (penable),
		.pwrite   (pwrite),
		.pready   (pready),
		.paddr    (paddr),
		.pwdata   (pwdata),
		.failures (failures),
		.pending  (pending),
		.checked  (checked)
	);

	// 4 ns clock.
	always begin
		#2 clk = 1'b1;
		#2 clk = 1'b0;
	end

	// Hard stop in case the core hangs.
	initial begin
		#4_000_000;
		$display("switching_activity_counter_core_test: FAIL");
		$finish;
	end

	function automatic logic [47:0] rand48();
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r[47:0];
	endfunction

	function automatic logic [63:0] rand_below(input logic [63:0] span);
		logic [63:0] r;
		r = {$urandom, $urandom};
		return r % span;
	endfunction

	// Setup phase, access phase, then an idle phase with psel low before the next transfer.
	task automatic apb_write(input logic [sac_pkg::APB_ADDR_WIDTH-1:0] addr,
			input logic [sac_pkg::APB_DATA_WIDTH-1:0] data);
		psel    <= 1'b1;
		penable <= 1'b0;
		pwrite  <= 1'b1;
		paddr   <= addr;
		pwdata  <= data;
		@(posedge clk);
		penable <= 1'b1;
		do @(posedge clk); while (!pready);
		psel    <= 1'b0;
		penable <= 1'b0;
		pwrite  <= 1'b0;
		@(posedge clk);
	endtask

	task automatic configure(input logic [47:0] window, input logic [31:0] period);
		apb_write(WINDOW_ADDR, {16'd0, window});
		apb_write(PERIOD_ADDR, {32'd0, period});
		settings_used++;
	endtask

	// Send one request; the sender runs in bursts separated by random gaps.
	task automatic send_item(input logic op, input logic [47:0] stamp, input logic [1:0] lv);
		int gap;
		if (burst_left == 0) begin
			gap = ($urandom_range(0, 3) == 0) ? 0 : $urandom_range(1, 15);
			burst_left = $urandom_range(1, 20);
			if (gap > 0) begin
				samples.valid <= 1'b0;
				repeat (gap) @(posedge clk);
			end
		end
		burst_left--;
		samples.valid       <= 1'b1;
		samples.op          <= op;
		samples.sample_time <= stamp;
		samples.level       <= lv;
		do @(posedge clk); while (!samples.ready);
		sent_items++;
		if (op == sac_pkg::OP_FINISH)
			sent_finishes++;
	endtask

	// Let every outstanding result drain before the registers change.
	task automatic settle();
		samples.valid <= 1'b0;
		do @(posedge clk); while (pending != 0);
		repeat (8) @(posedge clk);
	endtask

	// One well-formed trace: mostly rising times with random levels, now and
	// then a step back in time, closed by a finish.
	task automatic run_trace(input logic [63:0] window);
		int          count;
		logic [63:0] span;
		logic [63:0] stamp;
		logic [1:0]  lv;
		count = ($urandom_range(0, 9) == 0) ? 0 : $urandom_range(1, 14);
		span = window / 4 + 64'd1;
		stamp = rand_below(span);
		for (int i = 0; i < count; i++) begin
			if ($urandom_range(0, 3) == 0)
				lv = 2'($urandom_range(2, 3));
			else
				lv = 2'($urandom_range(0, 1));
			if (i > 0) begin
				if ($urandom_range(0, 11) == 0)
					stamp = stamp - rand_below(stamp + 64'd1);
				else
					stamp = stamp + rand_below(span);
			end
			send_item(sac_pkg::OP_SAMPLE, stamp[47:0], lv);
		end
		send_item(sac_pkg::OP_FINISH, rand48(), 2'($urandom_range(0, 3)));
	endtask

	// Receiver: one long hold-off once the random part starts, otherwise a
	// mix of open, coin-flip and mostly-stalled stretches.
	initial begin : receiver
		ready_mode_t mode;
		int          span;
		bit          hold_done;
		hold_done = 1'b0;
		results.ready = 1'b0;
		wait (arst_n === 1'b1);
		forever begin
			if (stress_go && !hold_done) begin
				hold_done = 1'b1;
				repeat (LONG_HOLD_CYCLES) begin
					@(posedge clk);
					results.ready <= 1'b0;
				end
			end else begin
				mode = ready_mode_t'($urandom_range(0, 2));
				span = $urandom_range(1, 40);
				repeat (span) begin
					@(posedge clk);
					case (mode)
						READY_OPEN:   results.ready <= 1'b1;
						READY_COIN:   results.ready <= ($urandom_range(0, 1) != 0);
						READY_SPARSE: results.ready <= ($urandom_range(0, 7) == 0);
						default:      results.ready <= 1'b1;
					endcase
				end
			end
		end
	end

	// Stimulus.
	initial begin : stimulus
		logic [47:0] window;
		logic [31:0] period;
		logic [63:0] trace_span;
		int          phase_start;
		int          guard;
		arst_n              = 1'b0;
		samples.valid       = 1'b0;
		samples.op          = sac_pkg::OP_SAMPLE;
		samples.sample_time = '0;
		samples.level       = sac_pkg::LEVEL_ZERO;
		psel                = 1'b0;
		penable             = 1'b0;
		pwrite              = 1'b0;
		paddr               = '0;
		pwdata              = '0;
		repeat (12) @(posedge clk);
		arst_n <= 1'b1;
		repeat (2) @(posedge clk);

		// Finish with no samples, changes between known levels and through X and Z,
		// a step back in time and a last change beyond the window.
		configure(48'd1000, 32'd10);
		send_item(sac_pkg::OP_FINISH, rand48(), sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd0, sac_pkg::LEVEL_ZERO);
		send_item(sac_pkg::OP_SAMPLE, 48'd100, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd250, sac_pkg::LEVEL_X);
		send_item(sac_pkg::OP_SAMPLE, 48'd300, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd400, sac_pkg::LEVEL_Z);
		send_item(sac_pkg::OP_SAMPLE, 48'd500, sac_pkg::LEVEL_ZERO);
		send_item(sac_pkg::OP_SAMPLE, 48'd600, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd450, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd1200, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_FINISH, rand48(), sac_pkg::LEVEL_ZERO);
		settle();

		// A zero window counts as one, so the high time overruns it; a zero
		// period gives no activity.
		configure(48'd0, 32'd0);
		send_item(sac_pkg::OP_SAMPLE, 48'd0, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd500, sac_pkg::LEVEL_ZERO);
		send_item(sac_pkg::OP_FINISH, rand48(), sac_pkg::LEVEL_Z);
		settle();

		// The high-time accumulator fills up and saturates.
		configure(TIME_TOP, PERIOD_TOP);
		send_item(sac_pkg::OP_SAMPLE, 48'd0, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, TIME_TOP, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd0, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, 48'd5, sac_pkg::LEVEL_ZERO);
		send_item(sac_pkg::OP_FINISH, rand48(), sac_pkg::LEVEL_X);
		settle();

		// Activity far beyond its range with a one-tick window.
		configure(48'd1, PERIOD_TOP);
		send_item(sac_pkg::OP_SAMPLE, 48'd3, sac_pkg::LEVEL_ZERO);
		send_item(sac_pkg::OP_SAMPLE, 48'd4, sac_pkg::LEVEL_ONE);
		send_item(sac_pkg::OP_SAMPLE, TIME_TOP, sac_pkg::LEVEL_ZERO);
		send_item(sac_pkg::OP_FINISH, rand48(), sac_pkg::LEVEL_ONE);
		settle();

		// Random traces under a series of register settings.
		stress_go = 1'b1;
		for (int phase = 0; phase < RANDOM_PHASES; phase++) begin
			case (phase)
				0: begin
					window = 48'($urandom_range(1, 5000));
					period = $urandom_range(1, 100);
				end
				1: begin
					window = TIME_TOP;
					period = PERIOD_TOP;
				end
				2: begin
					window = 48'd1;
					period = 32'd1;
				end
				3: begin
					window = rand48();
					period = $urandom;
				end
				4: begin
					window = 48'($urandom_range(100, 100000));
					period = 32'd0;
				end
				default: begin
					window = 48'd0;
					period = $urandom_range(1, 1000);
				end
			endcase
			configure(window, period);
			trace_span = (window < 48'd64) ? 64'd64 : {16'd0, window};
			phase_start = sent_items;
			while (sent_items - phase_start < PHASE_ITEMS) begin
				// Occasional raw request with any time and level.
				if ($urandom_range(0, 5) == 0)
					send_item(1'($urandom_range(0, 1)), rand48(), 2'($urandom_range(0, 3)));
				run_trace(trace_span);
			end
			settle();
		end

		// Drain, then give the verdict.
		samples.valid <= 1'b0;
		guard = 0;
		while (pending != 0 && guard < 20000) begin
			@(posedge clk);
			guard++;
		end
		repeat (20) @(posedge clk);
		$display("Sent %0d requests (%0d finishes) under %0d register settings,",
			sent_items, sent_finishes, settings_used);
		$display("covering X/Z levels, time steps back, saturation and a long stall;");
		$display("%0d results compared.", checked);
		if (failures == 0 && pending == 0) begin
			$display("switching_activity_counter_core_test: PASS");
		end else begin
			if (pending != 0)
				$display("%0t ns: %0d expected results never arrived", $time, pending);
			$display("switching_activity_counter_core_test: FAIL");
		end
		$finish;
	end
endmodule
